@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked at every rising edge, ignored while reset is asserted
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ sv/dmsrc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmsrc_pkg
// shared constants and types of the direct-mapped sealed result cache
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmsrc_pkg;

	// slot index width and table depth
	localparam int INDEX_BITS = 10;
	localparam int SLOT_COUNT = 1 << INDEX_BITS;

	// field widths
	localparam int KEY_W     = 64;
	localparam int PAYLOAD_W = 64;
	localparam int GEN_W     = 32;
	localparam int CMD_W     = 2;
	localparam int TAG_W     = 2 * KEY_W;
	localparam int DATA_W    = GEN_W + PAYLOAD_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR_ONE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 2'd3;

	// generation after reset and for never-written slots
	localparam logic [GEN_W-1:0] GEN_START = 32'd1;
	localparam logic [GEN_W-1:0] GEN_NONE  = 32'd0;

	// one word of the data memory
	typedef struct packed {
		logic [GEN_W-1:0]     gen;
		logic [PAYLOAD_W-1:0] payload;
	} slot_data_t;

	// request held in the read stage
	typedef struct packed {
		logic             valid;
		logic             lookup;
		logic [KEY_W-1:0] key_low;
		logic [KEY_W-1:0] key_high;
	} stage_t;

endpackage

`default_nettype wire

@@ sv/dmsrc_ram.sv @@
// ----------------------------------------------------------------------------
// dmsrc_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmsrc_ram #(
	parameter int WIDTH     = 64,
	parameter int ADDR_BITS = 10
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic                 re,
	input  wire logic [ADDR_BITS-1:0] addr,
	input  wire logic [WIDTH-1:0]     wdata,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [1 << ADDR_BITS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/dmsrc_lookup.sv @@
// ----------------------------------------------------------------------------
// dmsrc_lookup
// tag and generation compare plus the result register of the master side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmsrc_lookup
	import dmsrc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire stage_t               stage,
	input  wire logic [TAG_W-1:0]     tag_rd,
	input  wire slot_data_t           data_rd,
	input  wire logic [GEN_W-1:0]     generation,
	input  wire logic                 out_ready,
	output logic                      out_free,
	output logic                      out_valid,
	output logic                      out_hit,
	output logic [PAYLOAD_W-1:0]      out_payload
);

	logic                 valid_q;
	logic                 hit_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic                 hit_d;

	// result register can take a new transaction
	assign out_free = !valid_q || out_ready;

	// hit needs both signature words and the current generation
	assign hit_d = stage.lookup && (data_rd.gen == generation) &&
		(tag_rd == {stage.key_high, stage.key_low});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= stage.valid;
		end
	end

	// result payload, zero on miss
	always_ff @(posedge clk) begin
		if (out_free && stage.valid) begin
			hit_q     <= hit_d;
			payload_q <= hit_d ? data_rd.payload : '0;
		end
	end

	assign out_valid   = valid_q;
	assign out_hit     = hit_q;
	assign out_payload = payload_q;

endmodule

`default_nettype wire

@@ sv/direct_mapped_sealed_result_cache.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_sealed_result_cache
// direct-mapped cache of 64-bit payloads keyed by 128-bit signatures
// ----------------------------------------------------------------------------
// usage:
// requests enter on the slave stream: s_tuser holds the command (lookup,
// insert, clear one slot, clear all), s_tdata the key words and payload.
// every request gives exactly one result on the master stream: hit flag
// and payload, payload zero unless a lookup hit.
// a request passes the read stage, then the result register; one request
// is taken per cycle while s_tready is high, since each one does a single
// access to the tag and data memories in the accept cycle and the compare
// runs in the following cycle against the registered read data.
// after reset the block runs a clearing pass over all 1024 slots (one slot
// a cycle) that resets the slot generations in the data memory; s_tready
// stays low during the pass.
// when the receiver stalls, the result register holds and the read stage
// keeps one more request, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module direct_mapped_sealed_result_cache
	import dmsrc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [63:0] key_low, [127:64] key_high, [191:128] payload_in
	input  wire logic [191:0] s_tdata,
	// [1:0] command
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [0] hit, [64:1] payload_out, [71:65] zero
	output logic [71:0]       m_tdata
);

	logic [KEY_W-1:0]      key_low;
	logic [KEY_W-1:0]      key_high;
	logic [PAYLOAD_W-1:0]  payload_in;
	logic [INDEX_BITS-1:0] slot;
	logic                  accept;
	logic                  out_free;
	logic                  clr_busy_q;
	logic [INDEX_BITS-1:0] clr_cnt_q;
	logic [GEN_W-1:0]      gen_q;
	logic [GEN_W-1:0]      gen_inc;
	logic                  valid_s1;
	logic                  lookup_s1;
	logic [KEY_W-1:0]      key_low_s1;
	logic [KEY_W-1:0]      key_high_s1;
	stage_t                stage;
	logic                  tag_we;
	logic [TAG_W-1:0]      tag_wdata;
	logic [TAG_W-1:0]      tag_rd;
	logic                  data_we;
	logic [INDEX_BITS-1:0] data_addr;
	slot_data_t            data_wdata;
	slot_data_t            data_rd;
	logic [DATA_W-1:0]     data_rd_raw;
	logic                  out_hit;
	logic [PAYLOAD_W-1:0]  out_payload;

	// unpack the request
	assign key_low    = s_tdata[63:0];
	assign key_high   = s_tdata[127:64];
	assign payload_in = s_tdata[191:128];
	assign slot       = key_low[INDEX_BITS-1:0];

	// read stage moves on when empty or when the result register frees
	assign s_tready = !clr_busy_q && (!valid_s1 || out_free);
	assign accept   = s_tvalid && s_tready;

	// clearing pass over the slot generations after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// current generation, skips the never-written mark on wrap
	assign gen_inc = gen_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= GEN_START;
		end else if (accept && s_tuser == CMD_CLEAR_ALL) begin
			gen_q <= (gen_inc == GEN_NONE) ? GEN_START : gen_inc;
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			lookup_s1   <= (s_tuser == CMD_LOOKUP);
			key_low_s1  <= key_low;
			key_high_s1 <= key_high;
		end
	end

	assign stage = '{valid: valid_s1, lookup: lookup_s1,
		key_low: key_low_s1, key_high: key_high_s1};

	// tag memory: insert writes the key, clear-one writes zero
	assign tag_we    = accept && (s_tuser == CMD_INSERT || s_tuser == CMD_CLEAR_ONE);
	assign tag_wdata = (s_tuser == CMD_INSERT) ? {key_high, key_low} : '0;

	dmsrc_ram #(
		.WIDTH     (TAG_W),
		.ADDR_BITS (INDEX_BITS)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.re    (accept),
		.addr  (slot),
		.wdata (tag_wdata),
		.rdata (tag_rd)
	);

	// data memory: insert stamps payload and generation, clearing pass zeroes
	assign data_we   = clr_busy_q || (accept && s_tuser == CMD_INSERT);
	assign data_addr = clr_busy_q ? clr_cnt_q : slot;

	always_comb begin
		if (clr_busy_q) begin
			data_wdata.gen     = GEN_NONE;
			data_wdata.payload = '0;
		end else begin
			data_wdata.gen     = gen_q;
			data_wdata.payload = payload_in;
		end
	end

	dmsrc_ram #(
		.WIDTH     (DATA_W),
		.ADDR_BITS (INDEX_BITS)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.re    (accept),
		.addr  (data_addr),
		.wdata (data_wdata),
		.rdata (data_rd_raw)
	);

	assign data_rd = data_rd_raw;

	// compare and result register
	dmsrc_lookup u_lookup (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage       (stage),
		.tag_rd      (tag_rd),
		.data_rd     (data_rd),
		.generation  (gen_q),
		.out_ready   (m_tready),
		.out_free    (out_free),
		.out_valid   (m_tvalid),
		.out_hit     (out_hit),
		.out_payload (out_payload)
	);

	assign m_tdata = {7'b0, out_payload, out_hit};

	// checks
	`ASSERT_NEVER(a_no_accept_in_clear, clk, arst_n, clr_busy_q && s_tready, "request taken during clearing pass")
	`ASSERT_NEVER(a_gen_nonzero, clk, arst_n, gen_q == GEN_NONE, "generation reached the never-written mark")
	`ASSERT_PROP(a_gen_advances, clk, arst_n, (accept && s_tuser == CMD_CLEAR_ALL) |=> (gen_q != $past(gen_q)), "clear all did not advance generation")
	`ASSERT_PROP(a_miss_zero, clk, arst_n, (m_tvalid && !m_tdata[0]) |-> (m_tdata[64:1] == '0), "miss result carries a payload")

endmodule

`default_nettype wire
